// File: sv/sliding_energy_burst_detector_unit_macros.svh
// Assertion macros for the sliding energy burst detector.
// Each use is clocked on i_clk and disabled while i_rst_n is low.
`ifndef SLIDING_ENERGY_BURST_DETECTOR_UNIT_MACROS_SVH
`define SLIDING_ENERGY_BURST_DETECTOR_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define SEBD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("sebd: invariant violated");
`define SEBD_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("sebd: next-cycle check violated");
`else
`define SEBD_ASSERT(lbl, prop)
`define SEBD_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

// File: sv/sebd_pkg.sv
package sebd_pkg;

    localparam int ENERGY_W   = 32;   // stored energy per sample
    localparam int SUM_W      = 40;   // window sum and maximum
    localparam int IDX_W      = 32;   // wrapping sample number
    localparam int WINLEN_W   = 9;    // window_len register
    localparam int CFG_W      = 40;   // widest register
    localparam int WIN_RST    = 64;
    localparam logic [SUM_W-1:0] THRESH_RST = 40'h80_0000_0000;

    typedef enum logic [0:0] {
        CFG_WINDOW_LEN = 1'b0,
        CFG_THRESHOLD  = 1'b1
    } t_cfg_reg;

endpackage

// File: sv/sliding_energy_burst_detector_unit.sv
// Path: an accepted input word passes the input, stage 1, stage 2 and output registers to the master side.
// Throughput: one word per cycle unless stalled; the squaring stage, the single read port
// of the energy history and the one-add sum update each take one word every cycle.
// Reset (synchronous, active low): pipeline emptied, sum, counts and maximum cleared,
// window length 64, threshold 2^39; the history memory is not cleared and needs no pass.
`include "sliding_energy_burst_detector_unit_macros.svh"

module sliding_energy_burst_detector_unit #(
    parameter int MAX_WINDOW  = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,

    // configuration write port
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [sebd_pkg::CFG_W-1:0]  i_cfg_data,

    // input words
    input  logic                                       s_axis_tvalid,
    output logic                                       s_axis_tready,
    // tdata, low bit up: sample_i, sample_q, zero padding
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]         s_axis_tdata,

    // result words
    output logic                                       m_axis_tvalid,
    input  logic                                       m_axis_tready,
    // tdata, low bit up: window_sum[39:0], max_sum[79:40], max_index[111:80]
    output logic [2*sebd_pkg::SUM_W+sebd_pkg::IDX_W-1:0] m_axis_tdata,
    // tuser, low bit up: above_threshold, success
    output logic [1:0]                                 m_axis_tuser
);
    import sebd_pkg::*;

    localparam int S   = SAMPLE_BITS;
    localparam int AW  = $clog2(MAX_WINDOW);        // history address
    localparam int WW  = $clog2(MAX_WINDOW + 1);    // window length, fill count
    localparam int RW  = WW + 1;                    // run count, up to twice the window plus one
    localparam int CW  = (WW > WINLEN_W) ? WW : WINLEN_W;
    localparam int EW  = 2 * S + 1;
    localparam int EXW = (EW > ENERGY_W) ? EW : ENERGY_W;
    localparam int WIN_RST_EFF = (MAX_WINDOW < WIN_RST) ? MAX_WINDOW : WIN_RST;

    // ---------------------------------------------------------------
    // Configuration: hold the effective window (zero reads as one,
    // saturate at MAX_WINDOW) so no clamp sits in the data path.
    // ---------------------------------------------------------------
    logic [WW-1:0]    r_win;
    logic [SUM_W-1:0] r_thresh;
    logic             cfg_win_wr;
    logic             cfg_thr_wr;
    logic [CW-1:0]    cfg_len;
    logic [WW-1:0]    cfg_win_eff;

    always_comb begin
        cfg_win_wr = 1'b0;
        cfg_thr_wr = 1'b0;
        unique case (t_cfg_reg'(i_cfg_idx))
            CFG_WINDOW_LEN: cfg_win_wr = i_cfg_we;
            CFG_THRESHOLD:  cfg_thr_wr = i_cfg_we;
        endcase
    end

    always_comb begin
        cfg_len = CW'(i_cfg_data[WINLEN_W-1:0]);
        if (cfg_len == '0) begin
            cfg_win_eff = WW'(1);
        end else if (cfg_len > CW'(MAX_WINDOW)) begin
            cfg_win_eff = WW'(MAX_WINDOW);
        end else begin
            cfg_win_eff = WW'(cfg_len);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win    <= WW'(WIN_RST_EFF);
            r_thresh <= THRESH_RST;
        end else begin
            if (cfg_win_wr) begin
                r_win <= cfg_win_eff;
            end
            if (cfg_thr_wr) begin
                r_thresh <= i_cfg_data[SUM_W-1:0];
            end
        end
    end

    // ---------------------------------------------------------------
    // Handshake: each stage advances when the one after it has room.
    // ---------------------------------------------------------------
    logic r_v1, r_v2, r_v3, r_ov;
    logic rdy1, rdy2, rdy3;
    logic acc_in, adv1, adv2, adv3;

    assign rdy3          = !r_ov || m_axis_tready;
    assign rdy2          = !r_v3 || rdy3;
    assign rdy1          = !r_v2 || rdy2;
    assign s_axis_tready = !r_v1 || rdy1;
    assign acc_in        = s_axis_tvalid && s_axis_tready;
    assign adv1          = r_v1 && rdy1;
    assign adv2          = r_v2 && rdy2;
    assign adv3          = r_v3 && rdy3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (s_axis_tready) r_v1 <= s_axis_tvalid;
            if (rdy1)          r_v2 <= r_v1;
            if (rdy2)          r_v3 <= r_v2;
            if (rdy3)          r_ov <= r_v3;
        end
    end

    // ---------------------------------------------------------------
    // Input stage: tag each word with its sample number and its slot
    // in the history ring. The slot to drop lies one window behind.
    // The write pointer never restarts, so the tags are fixed at entry.
    // ---------------------------------------------------------------
    logic [IDX_W-1:0] r_sample_cnt;
    logic [AW-1:0]    r_wr_ptr;
    logic [WW:0]      wa_ext;
    logic [WW:0]      ra_ext;

    logic signed [S-1:0] r_si1, r_sq1;
    logic [IDX_W-1:0]    r_idx1;
    logic [AW-1:0]       r_wa1, r_ra1;

    always_comb begin
        wa_ext = (WW + 1)'(r_wr_ptr);
        if (wa_ext >= (WW + 1)'(r_win)) begin
            ra_ext = wa_ext - (WW + 1)'(r_win);
        end else begin
            ra_ext = wa_ext + (WW + 1)'(MAX_WINDOW) - (WW + 1)'(r_win);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_cnt <= '0;
            r_wr_ptr     <= '0;
        end else if (acc_in) begin
            r_sample_cnt <= r_sample_cnt + IDX_W'(1);
            if (r_wr_ptr == AW'(MAX_WINDOW - 1)) begin
                r_wr_ptr <= '0;
            end else begin
                r_wr_ptr <= r_wr_ptr + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_si1  <= s_axis_tdata[S-1:0];
            r_sq1  <= s_axis_tdata[2*S-1:S];
            r_idx1 <= r_sample_cnt;
            r_wa1  <= r_wr_ptr;
            r_ra1  <= AW'(ra_ext);
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: magnitudes and squares; write this energy and fetch the
    // energy leaving the window. Earlier words have all written by now,
    // and at full depth the read returns the entry before its overwrite.
    // ---------------------------------------------------------------
    logic [S-1:0]        mag_i, mag_q;
    logic [2*S-1:0]      sq_i, sq_q;
    logic [EXW-1:0]      e_full;
    logic [ENERGY_W-1:0] energy1;

    logic [ENERGY_W-1:0] r_hist [MAX_WINDOW];
    logic [ENERGY_W-1:0] r_e2, r_old2;
    logic [IDX_W-1:0]    r_idx2;

    always_comb begin
        mag_i   = r_si1[S-1] ? (~r_si1 + S'(1)) : r_si1;
        mag_q   = r_sq1[S-1] ? (~r_sq1 + S'(1)) : r_sq1;
        sq_i    = mag_i * mag_i;
        sq_q    = mag_q * mag_q;
        e_full  = EXW'(sq_i) + EXW'(sq_q);
        energy1 = e_full[ENERGY_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_hist[r_wa1] <= energy1;
            r_old2        <= r_hist[r_ra1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_e2   <= energy1;
            r_idx2 <= r_idx1;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: form the window delta ahead of the sum update.
    // ---------------------------------------------------------------
    logic [SUM_W-1:0] r_e3, r_diff3;
    logic [IDX_W-1:0] r_idx3;

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r_e3    <= SUM_W'(r_e2);
            r_diff3 <= SUM_W'(r_e2) - SUM_W'(r_old2);
            r_idx3  <= r_idx2;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: sum update, threshold test, run count and peak tracking.
    // While the window fills, add the energy alone; once full, add the
    // delta. A completed run restarts the history after reporting.
    // ---------------------------------------------------------------
    logic [SUM_W-1:0] r_sum,  n_sum;
    logic [WW-1:0]    r_fill, n_fill;
    logic [RW-1:0]    r_run,  n_run;
    logic [SUM_W-1:0] r_best, n_best;
    logic [IDX_W-1:0] r_bidx, n_bidx;

    logic             win_full;
    logic [SUM_W-1:0] sum_new;
    logic             n_above;
    logic             n_success;

    always_comb begin
        win_full  = (r_fill >= r_win);
        sum_new   = r_sum + (win_full ? r_diff3 : r_e3);
        n_above   = (sum_new > r_thresh);
        n_success = 1'b0;
        n_sum     = r_sum;
        n_fill    = r_fill;
        n_run     = r_run;
        n_best    = r_best;
        n_bidx    = r_bidx;

        if (adv3) begin
            n_sum  = sum_new;
            n_fill = win_full ? r_fill : r_fill + WW'(1);
            if (n_above) begin
                if (r_best < sum_new) begin
                    n_best = sum_new;
                    n_bidx = r_idx3;
                end
                if (r_run > {r_win, 1'b0}) begin
                    n_success = 1'b1;
                end else begin
                    n_run = r_run + RW'(1);
                end
            end else begin
                n_run  = '0;
                n_best = '0;
                n_bidx = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_fill <= '0;
            r_run  <= '0;
            r_best <= '0;
            r_bidx <= '0;
        end else if (cfg_win_wr || n_success) begin
            // restart the history; sample numbering runs on
            r_sum  <= '0;
            r_fill <= '0;
            r_run  <= '0;
            r_best <= '0;
            r_bidx <= '0;
        end else begin
            r_sum  <= n_sum;
            r_fill <= n_fill;
            r_run  <= n_run;
            r_best <= n_best;
            r_bidx <= n_bidx;
        end
    end

    // ---------------------------------------------------------------
    // Output register: report the values from before any restart.
    // ---------------------------------------------------------------
    logic             r_o_above, r_o_success;
    logic [SUM_W-1:0] r_o_sum, r_o_max;
    logic [IDX_W-1:0] r_o_idx;

    always_ff @(posedge i_clk) begin
        if (adv3) begin
            r_o_above   <= n_above;
            r_o_success <= n_success;
            r_o_sum     <= sum_new;
            r_o_max     <= n_best;
            r_o_idx     <= n_bidx;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {r_o_idx, r_o_max, r_o_sum};
    assign m_axis_tuser  = {r_o_success, r_o_above};

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    `SEBD_ASSERT(a_fill_in_window, r_fill <= r_win)
    `SEBD_ASSERT(a_run_bounded, r_run <= ({r_win, 1'b0} + RW'(1)))
    `SEBD_ASSERT(a_success_needs_high, !(r_ov && r_o_success) || r_o_above)
    `SEBD_ASSERT(a_low_clears_peak, !(r_ov && !r_o_above) || (r_o_max == '0 && r_o_idx == '0))
    `SEBD_ASSERT_NEXT(a_restart_clears, adv3 && n_success, r_sum == '0 && r_fill == '0 && r_run == '0)

endmodule
